// File: design/lsc_pkg.sv
package lsc_pkg;

	localparam int SENSOR_COUNT_DEF = 9;

	localparam int IDX_W     = 4;
	localparam int SAMPLE_W  = 12;
	localparam int POS_W     = 13;
	localparam int ISUM_W    = 14;
	localparam int WSUM_W    = 27;
	localparam int CFG_W     = 14;
	localparam int CFG_AW    = 1;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;

	localparam int FULL_SCALE  = 1000;
	localparam int WEIGHT_STEP = 500;
	localparam int LOW_CAL_RST = 4095;
	localparam int THRESH_RST  = 50;

	// shared divider: dividend wide enough for the weighted sum magnitude
	localparam int DIVD_W = WSUM_W;
	localparam int DIVS_W = ISUM_W;

	typedef enum logic [CFG_AW-1:0] {
		REG_CALIBRATE_MODE = 1'b0,
		REG_MIN_TOTAL      = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

// File: design/line_sensor_centroid.sv
// Line position from a reflectance sensor array. Each input word carries one
// 12-bit ADC sample and its sensor index. With calibrate_mode set, the sample
// widens that sensor's stored min/max and nothing comes out. Otherwise the
// sample is scaled to 0..1000 against its calibration and added into a
// weighted sum and an intensity sum, using the shared radix-2 divider that
// resolves one quotient bit per cycle over 27 bits (no division is needed
// when the scaled value is known to be zero). The word for the last sensor
// also divides the weighted sum by the intensity sum on the same divider and
// then emits one result word: the position, 1000 per sensor step and 0 at the
// centre, and a line_found flag that is clear (position 0) when the intensity
// sum is zero or below min_total_intensity. Indices at or above SENSOR_COUNT
// are dropped. A new word is taken while a result waits.
module line_sensor_centroid #(
	parameter int SENSOR_COUNT = lsc_pkg::SENSOR_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [lsc_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // sensor_index, sample
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [lsc_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // line_position
	output logic                           m_axis_tuser,  // line_found
	input  logic                           cfg_wen,
	input  logic [lsc_pkg::CFG_AW-1:0]     cfg_addr,
	input  logic [lsc_pkg::CFG_W-1:0]      cfg_wdata
);
	import lsc_pkg::*;

	localparam int CAL_AW  = $clog2(SENSOR_COUNT);
	localparam int DIFF_W  = SAMPLE_W + 1;
	localparam int V_W     = $clog2(FULL_SCALE + 1);
	localparam int WT_W    = 14;
	localparam int LANE_W  = IDX_W + 3;
	localparam int PROD_W  = V_W + 1 + WT_W;
	localparam int PMAX    = (SENSOR_COUNT - 1) * WEIGHT_STEP;
	localparam int PMAG_W  = $clog2(PMAX + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_PREP, S_DIVV, S_MUL, S_ACC, S_FIN, S_DIVP, S_EMIT
	} state_t;

	state_t state_q;

	logic                     cal_mode_q;
	logic [ISUM_W-1:0]        min_q;
	logic [SAMPLE_W-1:0]      low_cal_q  [SENSOR_COUNT];
	logic [SAMPLE_W-1:0]      high_cal_q [SENSOR_COUNT];
	logic [IDX_W-1:0]         idx_q;
	logic [SAMPLE_W-1:0]      smp_q;
	logic [V_W-1:0]           v_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [WSUM_W-1:0] wsum_q;
	logic [ISUM_W-1:0]        isum_q;
	logic                     neg_q;
	logic [POS_W-1:0]         pos_q;
	logic                     found_q;
	logic                     m_valid_q;
	logic [POS_W-1:0]         m_pos_q;
	logic                     m_found_q;
	div_req_t                 div_req_q;
	div_rsp_t                 div_rsp;

	logic [SAMPLE_W-1:0]      lo;
	logic [SAMPLE_W-1:0]      hi;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] span;
	logic [SAMPLE_W-1:0]      diff_mag;
	logic [SAMPLE_W-1:0]      span_mag;
	logic                     skip;
	logic signed [LANE_W-1:0] lane;
	logic signed [WT_W-1:0]   wt;
	logic                     in_range;
	logic                     last;
	logic                     found;
	logic [DIVD_W-1:0]        wsum_mag;
	logic [PMAG_W-1:0]        pmag;
	logic signed [POS_W:0]    pos_full;
	logic                     out_free;

	assign in_range = idx_q < IDX_W'(SENSOR_COUNT);
	assign last     = idx_q == IDX_W'(SENSOR_COUNT - 1);
	assign lo       = low_cal_q[idx_q[CAL_AW-1:0]];
	assign hi       = high_cal_q[idx_q[CAL_AW-1:0]];
	assign diff     = $signed({1'b0, smp_q}) - $signed({1'b0, lo});
	assign span     = $signed({1'b0, hi}) - $signed({1'b0, lo});
	assign diff_mag = diff[DIFF_W-1] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
	assign span_mag = span[DIFF_W-1] ? SAMPLE_W'(-span) : span[SAMPLE_W-1:0];
	assign skip     = (span == '0) || (diff == '0) || (diff[DIFF_W-1] != span[DIFF_W-1]);

	assign lane = $signed({2'b00, idx_q, 1'b0}) - LANE_W'(SENSOR_COUNT - 1);
	assign wt   = WT_W'(lane) * WT_W'(WEIGHT_STEP);

	assign found    = (isum_q != '0) && (isum_q >= min_q);
	assign wsum_mag = wsum_q[WSUM_W-1] ? DIVD_W'(-wsum_q) : DIVD_W'(wsum_q);
	assign pmag     = (div_rsp.quotient > DIVD_W'(PMAX)) ? PMAG_W'(PMAX)
	                                                     : div_rsp.quotient[PMAG_W-1:0];
	assign pos_full = neg_q ? -$signed((POS_W+1)'(pmag)) : $signed((POS_W+1)'(pmag));

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(m_pos_q);
	assign m_axis_tuser  = m_found_q;

	lsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_mode_q <= 1'b0;
			min_q      <= ISUM_W'(THRESH_RST);
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_CALIBRATE_MODE: cal_mode_q <= cfg_wdata[0];
				REG_MIN_TOTAL:      min_q      <= cfg_wdata[ISUM_W-1:0];
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				low_cal_q[i]  <= SAMPLE_W'(LOW_CAL_RST);
				high_cal_q[i] <= '0;
			end
		end else if (state_q == S_PREP && in_range && cal_mode_q) begin
			if (smp_q < lo)
				low_cal_q[idx_q[CAL_AW-1:0]] <= smp_q;
			if (smp_q > hi)
				high_cal_q[idx_q[CAL_AW-1:0]] <= smp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_req_q <= '0;
			wsum_q    <= '0;
			isum_q    <= '0;
			m_valid_q <= 1'b0;
			idx_q     <= '0;
			smp_q     <= '0;
			v_q       <= '0;
			prod_q    <= '0;
			neg_q     <= 1'b0;
			pos_q     <= '0;
			found_q   <= 1'b0;
			m_pos_q   <= '0;
			m_found_q <= 1'b0;
		end else begin
			div_req_q.start <= (state_q == S_PREP && in_range && !cal_mode_q && !skip)
			                   || (state_q == S_FIN && found);
			if (state_q == S_EMIT && out_free)
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_axis_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						idx_q   <= s_axis_tdata[IDX_W-1:0];
						smp_q   <= s_axis_tdata[IDX_W +: SAMPLE_W];
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (!in_range || cal_mode_q) begin
						state_q <= S_IDLE;
					end else if (skip) begin
						v_q     <= '0;
						state_q <= S_MUL;
					end else begin
						div_req_q.dividend <= DIVD_W'(diff_mag) * DIVD_W'(FULL_SCALE);
						div_req_q.divisor  <= DIVS_W'(span_mag);
						state_q            <= S_DIVV;
					end
				end
				S_DIVV: begin
					if (div_rsp.done) begin
						v_q <= (div_rsp.quotient > DIVD_W'(FULL_SCALE)) ? V_W'(FULL_SCALE)
						                                               : div_rsp.quotient[V_W-1:0];
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= PROD_W'($signed({1'b0, v_q})) * PROD_W'(wt);
					state_q <= S_ACC;
				end
				S_ACC: begin
					wsum_q  <= wsum_q + WSUM_W'(prod_q);
					isum_q  <= isum_q + ISUM_W'(v_q);
					state_q <= last ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					if (found) begin
						neg_q              <= wsum_q[WSUM_W-1];
						div_req_q.dividend <= wsum_mag;
						div_req_q.divisor  <= isum_q;
						state_q            <= S_DIVP;
					end else begin
						pos_q   <= '0;
						found_q <= 1'b0;
						state_q <= S_EMIT;
					end
				end
				S_DIVP: begin
					if (div_rsp.done) begin
						pos_q   <= pos_full[POS_W-1:0];
						found_q <= 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						m_pos_q   <= pos_q;
						m_found_q <= found_q;
						wsum_q    <= '0;
						isum_q    <= '0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_line_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_found_q |-> m_pos_q == '0) else $error("no-line result not zero");
	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && out_free |=> wsum_q == '0 && isum_q == '0)
		else $error("sums not cleared after frame");
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !div_rsp.busy) else $error("divider busy while idle");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && !out_free |=> m_valid_q && state_q == S_EMIT)
		else $error("result lost while output held");
`endif

endmodule

// File: design/lsc_div.sv
module lsc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lsc_pkg::div_req_t req,
	output lsc_pkg::div_rsp_t rsp
);
	import lsc_pkg::*;

	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVS_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], fits};
			rem_q <= fits ? DIVS_W'(trial - {1'b0, dvs_q}) : trial[DIVS_W-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without a run");
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0) else $error("busy with spent count");
`endif

endmodule

// File: verif/tb_top.sv
module tb_top;
	import lsc_pkg::*;

	localparam int SENSORS     = SENSOR_COUNT_DEF;
	localparam int LAST        = SENSORS - 1;
	localparam longint POS_MAX = longint'(LAST) * WEIGHT_STEP;
	localparam int ITEM_TARGET = 650;
	localparam int SETTLE_CYC  = 120;
	localparam int LIMIT_CYC   = 500000;

	typedef struct {
		logic [POS_W-1:0] pos;
		logic             found;
	} centroid_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_wen;
	logic [CFG_AW-1:0]     cfg_addr;
	logic [CFG_W-1:0]      cfg_wdata;

	// predictor state
	logic [SAMPLE_W-1:0]      cal_lo [SENSORS];
	logic [SAMPLE_W-1:0]      cal_hi [SENSORS];
	logic signed [WSUM_W-1:0] wsum_m;
	logic [ISUM_W-1:0]        isum_m;
	logic                     mode_cal;
	logic [ISUM_W-1:0]        min_total;

	centroid_t pending_centroids[$];
	int        mismatches  = 0;
	int        cycle_count = 0;
	int        words_sent  = 0;
	int        hold_cycles = 0;
	bit        tx_gaps     = 1'b1;
	bit        rx_gaps     = 1'b1;

	line_sensor_centroid DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wen       (cfg_wen),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint sensor_weight(int idx);
		return longint'(2 * idx - LAST) * WEIGHT_STEP;
	endfunction

	function automatic void accumulate_position(logic [IDX_W-1:0] idx, logic [SAMPLE_W-1:0] smp);
		longint lo, hi, v, q;
		centroid_t res;
		if (idx >= SENSORS)
			return;
		if (mode_cal) begin
			if (smp < cal_lo[idx]) cal_lo[idx] = smp;
			if (smp > cal_hi[idx]) cal_hi[idx] = smp;
			return;
		end
		lo = cal_lo[idx];
		hi = cal_hi[idx];
		if (hi == lo) begin
			v = 0;
		end else begin
			v = ((longint'(smp) - lo) * FULL_SCALE) / (hi - lo);
			if (v < 0) v = 0;
			if (v > FULL_SCALE) v = FULL_SCALE;
		end
		wsum_m = WSUM_W'(longint'(wsum_m) + v * sensor_weight(idx));
		isum_m = isum_m + ISUM_W'(v);
		if (idx != LAST)
			return;
		if (isum_m == 0 || isum_m < min_total) begin
			res.pos   = '0;
			res.found = 1'b0;
		end else begin
			q = longint'(wsum_m) / longint'(isum_m);
			if (q > POS_MAX) q = POS_MAX;
			if (q < -POS_MAX) q = -POS_MAX;
			res.pos   = POS_W'(q);
			res.found = 1'b1;
		end
		pending_centroids.push_back(res);
		wsum_m = '0;
		isum_m = '0;
	endfunction

	function automatic void report_mismatch(string what, centroid_t want,
			logic [POS_W-1:0] got_pos, logic got_found);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch (%s): expected position %0d found %0b, got position %0d found %0b",
				what, $signed(want.pos), want.found, $signed(got_pos), got_found);
	endfunction

	// check results, then track accepted words and register writes
	always @(posedge clk) begin
		centroid_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_centroids.size() == 0) begin
					want.pos   = '0;
					want.found = 1'b0;
					report_mismatch("unexpected word", want, m_axis_tdata[POS_W-1:0], m_axis_tuser);
				end else begin
					want = pending_centroids.pop_front();
					if (m_axis_tdata[POS_W-1:0] !== want.pos || m_axis_tuser !== want.found)
						report_mismatch("field", want, m_axis_tdata[POS_W-1:0], m_axis_tuser);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				accumulate_position(s_axis_tdata[IDX_W-1:0], s_axis_tdata[IDX_W +: SAMPLE_W]);
			if (cfg_wen) begin
				case (cfg_addr)
					REG_CALIBRATE_MODE: mode_cal = cfg_wdata[0];
					REG_MIN_TOTAL:      min_total = cfg_wdata[ISUM_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			m_axis_tready <= !rx_gaps || ($urandom_range(99) >= 35);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYC) begin
			$display("FAIL line_sensor_centroid");
			$finish;
		end
	end

	task automatic send_word(logic [IDX_W-1:0] idx, logic [SAMPLE_W-1:0] smp);
		while (tx_gaps && $urandom_range(99) < 35) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {smp, idx};
		do @(posedge clk); while (!s_axis_tready);
		if (idx < SENSORS)
			words_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_centroids.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t which, logic [CFG_W-1:0] val);
		cfg_wen   <= 1'b1;
		cfg_addr  <= which;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample(int idx);
		logic [SAMPLE_W-1:0] a, b;
		a = cal_lo[idx];
		b = cal_hi[idx];
		case ($urandom_range(5))
			0:       return a;
			1:       return b;
			2, 3:    return SAMPLE_W'($urandom_range(a, b));
			4:       return SAMPLE_W'($urandom_range(4095));
			default: return $urandom_range(1) ? 12'd4095 : 12'd0;
		endcase
	endfunction

	task automatic send_frame();
		int  centre;
		bit  shaped;
		centre = $urandom_range(LAST);
		shaped = ($urandom_range(1) != 0);
		for (int i = 0; i < SENSORS; i++) begin
			if (!shaped)
				send_word(IDX_W'(i), pick_sample(i));
			else if (i == centre)
				send_word(IDX_W'(i), cal_hi[i]);
			else
				send_word(IDX_W'(i), cal_lo[i]);
		end
	endtask

	// broken frames: stray and out-of-range indices, long runs on one sensor
	task automatic send_noise();
		int               len;
		logic [IDX_W-1:0] pin_idx;
		bit               one_sensor;
		len        = $urandom_range(30, 1);
		pin_idx    = IDX_W'($urandom_range(LAST));
		one_sensor = ($urandom_range(3) == 0);
		for (int n = 0; n < len; n++) begin
			if (one_sensor)
				send_word(pin_idx, cal_hi[pin_idx]);
			else
				send_word(IDX_W'($urandom_range(15)), SAMPLE_W'($urandom_range(4095)));
		end
		if ($urandom_range(1))
			send_word(IDX_W'(LAST), pick_sample(LAST));
	endtask

	task automatic recalibrate();
		write_reg(REG_CALIBRATE_MODE, 14'd1);
		repeat ($urandom_range(20, 4)) begin
			if ($urandom_range(1))
				send_word(IDX_W'($urandom_range(15)), SAMPLE_W'($urandom_range(4095)));
			else
				send_word(IDX_W'($urandom_range(LAST)), SAMPLE_W'(2000 + $urandom_range(100)));
		end
		settle();
		write_reg(REG_CALIBRATE_MODE, 14'd0);
	endtask

	task automatic test_uncalibrated_frame();
		for (int i = 0; i < LAST; i++)
			send_word(IDX_W'(i), (i == 4) ? 12'h800 : (i[0] ? 12'd4095 : 12'd0));
		send_word(4'd9, 12'hAAA);
		send_word(4'd15, 12'h555);
		send_word(IDX_W'(LAST), 12'd0);
		settle();
	endtask

	// leave sensor 3 uncalibrated and sensor 4 with an empty range
	task automatic test_calibration();
		write_reg(REG_CALIBRATE_MODE, 14'd1);
		send_word(4'd0, 12'd0);
		send_word(4'd0, 12'd4095);
		for (int i = 1; i < SENSORS; i++) begin
			if (i != 3 && i != 4) begin
				send_word(IDX_W'(i), SAMPLE_W'($urandom_range(1500)));
				send_word(IDX_W'(i), SAMPLE_W'($urandom_range(4095, 2500)));
			end
		end
		send_word(4'd4, 12'd1234);
		send_word(4'd12, 12'd7);
		settle();
		write_reg(REG_CALIBRATE_MODE, 14'd0);
	endtask

	task automatic test_zero_sum();
		write_reg(REG_MIN_TOTAL, 14'd0);
		for (int i = 0; i < SENSORS; i++)
			send_word(IDX_W'(i), cal_lo[i]);
		settle();
	endtask

	task automatic test_backpressure();
		tx_gaps     = 1'b0;
		hold_cycles = 1200;
		repeat (3) send_frame();
		tx_gaps = 1'b1;
		settle();
	endtask

	task automatic test_random_phases();
		int               phase;
		logic [CFG_W-1:0] thr;
		phase = 0;
		while (words_sent < ITEM_TARGET) begin
			case (phase)
				0: thr = 14'h3FFF;
				1: thr = 14'd0;
				default: begin
					case ($urandom_range(3))
						0:       thr = CFG_W'($urandom_range(16383));
						1:       thr = CFG_W'($urandom_range(THRESH_RST));
						default: thr = CFG_W'($urandom_range(3000));
					endcase
				end
			endcase
			write_reg(REG_MIN_TOTAL, thr);
			if (phase > 1 && $urandom_range(2) == 0)
				recalibrate();
			tx_gaps = (phase % 5 != 3);
			rx_gaps = tx_gaps;
			repeat ($urandom_range(8, 3)) begin
				if ($urandom_range(4) == 0)
					send_noise();
				else
					send_frame();
			end
			settle();
			phase++;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_wen       = 1'b0;
		cfg_addr      = REG_CALIBRATE_MODE;
		cfg_wdata     = '0;
		for (int i = 0; i < SENSORS; i++) begin
			cal_lo[i] = SAMPLE_W'(LOW_CAL_RST);
			cal_hi[i] = '0;
		end
		wsum_m    = '0;
		isum_m    = '0;
		mode_cal  = 1'b0;
		min_total = ISUM_W'(THRESH_RST);
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_uncalibrated_frame();
		test_calibration();
		test_zero_sum();
		test_backpressure();
		test_random_phases();

		if (mismatches == 0)
			$display("PASS line_sensor_centroid");
		else
			$display("FAIL line_sensor_centroid");
		$finish;
	end

endmodule

// File: files.f
design/lsc_pkg.sv
design/lsc_div.sv
design/line_sensor_centroid.sv
verif/tb_top.sv
